// File: hdl/hpp_pkg.sv
// host:port text parser package
// types, character codes and limits shared by hpp_step and host_port_text_parser_core
// no dependencies
package hpp_pkg;

    // parser phase within one text
    typedef enum logic [2:0] {
        PH_START,
        PH_BR_HOST,
        PH_BR_AFTER,
        PH_PLAIN_HOST,
        PH_PORT_EMPTY,
        PH_PORT,
        PH_FAIL
    } t_phase;

    // one result transaction
    typedef struct packed {
        logic [15:0] port_number;
        logic [7:0]  host_length;
        logic        host_offset;
        logic        bracketed;
        logic        ok;
    } t_result;

    localparam logic [7:0]  CH_LBRACKET = 8'h5B;
    localparam logic [7:0]  CH_RBRACKET = 8'h5D;
    localparam logic [7:0]  CH_COLON    = 8'h3A;
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_NINE     = 8'h39;

    localparam logic [19:0] PORT_MAX    = 20'd65535;
    localparam logic [7:0]  HOST_SAT    = 8'hFF;

endpackage

// File: hdl/hpp_step.sv
// per-character state update and result generation of the host:port parser
// holds phase, position, host count and port value; depends on hpp_pkg
module hpp_step #(
    parameter int MAX_TEXT_LENGTH = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_ch,
    input  logic            i_last,
    output hpp_pkg::t_result o_result
);

    localparam int POS_W = $clog2(MAX_TEXT_LENGTH + 2);
    localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(MAX_TEXT_LENGTH);

    hpp_pkg::t_phase  r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_host, n_host;
    logic [15:0]      r_port, n_port;
    logic             r_bracket, n_bracket;
    logic             n_too_long;

    logic             is_digit;
    logic [3:0]       digit;
    logic [19:0]      port_sum;
    logic [7:0]       host_inc;

    assign is_digit = (i_ch >= hpp_pkg::CH_ZERO) && (i_ch <= hpp_pkg::CH_NINE);
    assign digit    = 4'(i_ch - hpp_pkg::CH_ZERO);
    // accum * 10 as two shifts
    assign port_sum = ({4'b0, r_port} << 3) + ({4'b0, r_port} << 1) + {16'b0, digit};
    assign host_inc = (r_host != hpp_pkg::HOST_SAT) ? r_host + 8'd1 : r_host;

    // next state
    always_comb begin
        n_pos      = (r_pos <= TEXT_LIMIT) ? r_pos + POS_W'(1) : r_pos;
        n_too_long = (n_pos > TEXT_LIMIT);
        n_phase    = r_phase;
        n_host     = r_host;
        n_port     = r_port;
        n_bracket  = r_bracket;
        case (r_phase)
            hpp_pkg::PH_START: begin
                if (i_ch == hpp_pkg::CH_LBRACKET) begin
                    n_bracket = 1'b1;
                    n_phase   = hpp_pkg::PH_BR_HOST;
                end else if (i_ch == hpp_pkg::CH_COLON) begin
                    n_phase = hpp_pkg::PH_FAIL;
                end else begin
                    n_host  = host_inc;
                    n_phase = hpp_pkg::PH_PLAIN_HOST;
                end
            end
            hpp_pkg::PH_BR_HOST: begin
                if (i_ch == hpp_pkg::CH_RBRACKET) begin
                    n_phase = (r_host == 8'd0) ? hpp_pkg::PH_FAIL : hpp_pkg::PH_BR_AFTER;
                end else begin
                    n_host = host_inc;
                end
            end
            hpp_pkg::PH_BR_AFTER: begin
                n_phase = (i_ch == hpp_pkg::CH_COLON) ? hpp_pkg::PH_PORT_EMPTY
                                                      : hpp_pkg::PH_FAIL;
            end
            hpp_pkg::PH_PLAIN_HOST: begin
                if (i_ch == hpp_pkg::CH_COLON) begin
                    n_phase = hpp_pkg::PH_PORT_EMPTY;
                end else begin
                    n_host = host_inc;
                end
            end
            hpp_pkg::PH_PORT_EMPTY, hpp_pkg::PH_PORT: begin
                if (is_digit && (port_sum <= hpp_pkg::PORT_MAX)) begin
                    n_port  = port_sum[15:0];
                    n_phase = hpp_pkg::PH_PORT;
                end else begin
                    n_phase = hpp_pkg::PH_FAIL;
                end
            end
            default: begin
                n_phase = hpp_pkg::PH_FAIL;
            end
        endcase
    end

    // result of a text ending on this character
    always_comb begin
        o_result = '0;
        if ((n_phase == hpp_pkg::PH_PORT) && (n_port != 16'd0) && !n_too_long) begin
            o_result.ok          = 1'b1;
            o_result.bracketed   = n_bracket;
            o_result.host_offset = n_bracket;
            o_result.host_length = n_host;
            o_result.port_number = n_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase   <= hpp_pkg::PH_START;
            r_pos     <= '0;
            r_host    <= '0;
            r_port    <= '0;
            r_bracket <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_host    <= n_host;
            r_port    <= n_port;
            r_bracket <= n_bracket;
        end
    end

endmodule

// File: hdl/host_port_text_parser_core.sv
// top level of the host:port text parser: input register, step logic, result register
// depends on hpp_pkg and hpp_step
//
// Takes an address text one character per transaction on the slave side, the final
// character flagged by tlast, and checks it against host:port or [host]:port. After
// the final character one result transaction leaves on the master side carrying ok,
// bracketed, host offset, host length and port number; all fields but ok read zero
// when the text is rejected. Texts longer than MAX_TEXT_LENGTH characters are
// rejected. Throughput is one character per clock: a character sits in the input
// register and is folded into the parser state by a single short pass
// (compare, saturating count and a times-ten add for the port digits). The result
// register takes the verdict at the same edge as the final character leaves the
// input register and offers it from there on; the slave side only stalls when a final
// character meets a result register that is still full and not being taken. No
// other characters wait.
module host_port_text_parser_core #(
    parameter int MAX_TEXT_LENGTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // last character of the text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [0] ok, [1] bracketed, [2] host_offset,
                                     // [10:3] host_length, [26:11] port_number, rest zero
);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_ch;
    logic             r_in_last;

    // result register
    logic             r_out_valid;
    hpp_pkg::t_result r_out;

    hpp_pkg::t_result step_result;
    logic             out_free;
    logic             step_fire;

    // a result slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    // non-final characters never need the result slot
    assign step_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    hpp_step #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_fire),
        .i_ch     (r_in_ch),
        .i_last   (r_in_last),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.port_number, r_out.host_length,
                         r_out.host_offset, r_out.bracketed, r_out.ok};

    // an accepted text never carries port zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[26:11] != 16'd0))
        else $error("accepted text with port zero");

    // a rejected text reports all-zero fields
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[31:1] == 31'd0))
        else $error("rejected text with non-zero fields");

    // an accepted text has a non-empty host, offset tracking the bracket flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
            ((o_m_tdata[10:3] != 8'd0) && (o_m_tdata[2] == o_m_tdata[1])))
        else $error("accepted text with empty host or wrong offset");

    // the slave side is held off only by a pending final character
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked result");

    // nothing leaves straight after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

// File: verif/testbench.sv
// self-checking testbench for host_port_text_parser_core
// streams address texts through the slave side and checks every verdict on the master side
// depends on hpp_pkg and the parser rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TEXT_LENGTH = 255;
    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int HOLD_CYCLES     = 200;  // long receiver hold-off in the last stage
    localparam int CHARS_PER_STAGE = 110;  // characters queued per random stage
    localparam int DRAIN_CYCLES    = 16;   // result path is two registers deep
    localparam int CYCLE_LIMIT     = 400000;

    typedef logic [7:0] t_text[$];

    // one character transaction as offered on the slave side
    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } t_char_item;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;  // [7:0] ch
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [0] ok, [1] bracketed, [2] host_offset,
                                   // [10:3] host_length, [26:11] port_number

    // characters waiting for the driver, filled by the stimulus process
    t_char_item  pending_chars[$];
    t_char_item  next_item;
    int          chars_queued = 0;

    // expected result words, oldest first, padding bits included
    logic [31:0]      expected_verdicts[$];
    logic [31:0]      expected_word;
    hpp_pkg::t_result want, got;
    int               mismatch_count = 0;

    // idling percentages, changed by the stimulus process on the falling edge
    int          send_idle_pct = 15;
    int          recv_idle_pct = 50;

    // long receiver hold-off, counted in its own process
    logic        hold_armed = 1'b0;
    int          hold_count = 0;
    wire         hold_active = hold_armed && (hold_count < HOLD_CYCLES);

    int          cycle_count = 0;

    // shadow parser state
    hpp_pkg::t_phase parse_phase;
    int              text_chars;
    int              host_chars;
    int              port_value;
    logic            in_brackets;
    logic            over_length;

    host_port_text_parser_core #(
        .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // back to the start of a text
    task automatic reset_parser();
        parse_phase = hpp_pkg::PH_START;
        text_chars  = 0;
        host_chars  = 0;
        port_value  = 0;
        in_brackets = 1'b0;
        over_length = 1'b0;
    endtask

    // fold one accepted character into the shadow state, queue a verdict on the final one
    task automatic parse_char(input logic [7:0] ch, input logic last);
        int               next_port;
        hpp_pkg::t_result verdict;
        // character count saturates just past the limit
        if (text_chars <= MAX_TEXT_LENGTH)
            text_chars++;
        if (text_chars > MAX_TEXT_LENGTH)
            over_length = 1'b1;
        case (parse_phase)
            hpp_pkg::PH_START: begin
                if (ch == hpp_pkg::CH_LBRACKET) begin
                    in_brackets = 1'b1;
                    parse_phase = hpp_pkg::PH_BR_HOST;
                end else if (ch == hpp_pkg::CH_COLON) begin
                    parse_phase = hpp_pkg::PH_FAIL;
                end else begin
                    host_chars++;
                    parse_phase = hpp_pkg::PH_PLAIN_HOST;
                end
            end
            hpp_pkg::PH_BR_HOST: begin
                // a colon inside the brackets is part of the host
                if (ch == hpp_pkg::CH_RBRACKET)
                    parse_phase = (host_chars == 0) ? hpp_pkg::PH_FAIL : hpp_pkg::PH_BR_AFTER;
                else
                    host_chars++;
            end
            hpp_pkg::PH_BR_AFTER: begin
                parse_phase = (ch == hpp_pkg::CH_COLON) ? hpp_pkg::PH_PORT_EMPTY
                                                        : hpp_pkg::PH_FAIL;
            end
            hpp_pkg::PH_PLAIN_HOST: begin
                if (ch == hpp_pkg::CH_COLON)
                    parse_phase = hpp_pkg::PH_PORT_EMPTY;
                else
                    host_chars++;
            end
            hpp_pkg::PH_PORT_EMPTY, hpp_pkg::PH_PORT: begin
                if (ch >= hpp_pkg::CH_ZERO && ch <= hpp_pkg::CH_NINE) begin
                    next_port = port_value * 10 + (int'(ch) - int'(hpp_pkg::CH_ZERO));
                    if (next_port > int'(hpp_pkg::PORT_MAX)) begin
                        parse_phase = hpp_pkg::PH_FAIL;
                    end else begin
                        port_value  = next_port;
                        parse_phase = hpp_pkg::PH_PORT;
                    end
                end else begin
                    parse_phase = hpp_pkg::PH_FAIL;
                end
            end
            default: parse_phase = hpp_pkg::PH_FAIL;
        endcase

        if (last) begin
            verdict = '0;
            if (parse_phase == hpp_pkg::PH_PORT && port_value != 0 && !over_length) begin
                verdict.ok          = 1'b1;
                verdict.bracketed   = in_brackets;
                verdict.host_offset = in_brackets;
                verdict.host_length = (host_chars > 255) ? hpp_pkg::HOST_SAT
                                                         : 8'(host_chars);
                verdict.port_number = 16'(port_value);
            end
            expected_verdicts.push_back({5'd0, verdict});
            reset_parser();
        end
    endtask

    // random character, weighted towards the ones the parser reacts to
    function automatic logic [7:0] rand_char();
        case ($urandom_range(7))
            0:       return hpp_pkg::CH_LBRACKET;
            1:       return hpp_pkg::CH_RBRACKET;
            2:       return hpp_pkg::CH_COLON;
            3, 4:    return hpp_pkg::CH_ZERO + 8'($urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // queue one text, tlast on its final character
    task automatic push_text(input t_text txt);
        t_char_item item;
        for (int i = 0; i < txt.size(); i++) begin
            item.ch   = txt[i];
            item.last = (i == txt.size() - 1);
            pending_chars.push_back(item);
        end
        chars_queued += txt.size();
    endtask

    task automatic push_string(input string s);
        t_text txt;
        foreach (s[i])
            txt.push_back(s[i]);
        push_text(txt);
    endtask

    // host of repeated letters followed by :80, for the length limit
    task automatic push_filled_host(input bit with_brackets, input int host_len);
        t_text txt;
        if (with_brackets)
            txt.push_back(hpp_pkg::CH_LBRACKET);
        repeat (host_len)
            txt.push_back("h");
        if (with_brackets)
            txt.push_back(hpp_pkg::CH_RBRACKET);
        txt.push_back(hpp_pkg::CH_COLON);
        txt.push_back("8");
        txt.push_back(hpp_pkg::CH_ZERO);
        push_text(txt);
    endtask

    // mostly well-formed addresses with random content, mixed with broken ones, noise and long hosts
    task automatic push_random_text();
        t_text      txt;
        string      digits;
        logic [7:0] b;
        int         kind;
        int         host_len;
        int         n;
        bit         with_brackets;
        kind = $urandom_range(999);
        if (kind >= 800 && kind < 990) begin
            // plain noise
            n = $urandom_range(1, 12);
            repeat (n)
                txt.push_back(rand_char());
        end else begin
            with_brackets = $urandom_range(1);
            if (kind >= 990)
                host_len = $urandom_range(MAX_TEXT_LENGTH - 10, MAX_TEXT_LENGTH - 3);
            else
                host_len = $urandom_range(1, 10);
            if (with_brackets) begin
                if ($urandom_range(15) == 0)
                    host_len = 0;
                txt.push_back(hpp_pkg::CH_LBRACKET);
                repeat (host_len) begin
                    do b = rand_char(); while (b == hpp_pkg::CH_RBRACKET);
                    txt.push_back(b);
                end
                txt.push_back(hpp_pkg::CH_RBRACKET);
            end else begin
                // an opening bracket first would make the text bracketed
                repeat (host_len) begin
                    do b = rand_char();
                    while (b == hpp_pkg::CH_COLON ||
                           (txt.size() == 0 && b == hpp_pkg::CH_LBRACKET));
                    txt.push_back(b);
                end
            end
            txt.push_back(hpp_pkg::CH_COLON);
            case ($urandom_range(9))
                0:       digits = "0";
                1:       digits = "65535";
                2:       digits = $sformatf("%0d", $urandom_range(65536, 999999));
                3:       digits = "";
                4:       digits = $sformatf("%0d", $urandom_range(1, 99));
                default: digits = $sformatf("%0d", $urandom_range(1, 65535));
            endcase
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2))
                    digits = {"0", digits};
            foreach (digits[i])
                txt.push_back(digits[i]);
            if (kind >= 600 && kind < 800) begin
                // break the address in one place
                n = $urandom_range(txt.size() - 1);
                case ($urandom_range(2))
                    0:       txt[n] = rand_char();
                    1:       txt.insert(n, hpp_pkg::CH_COLON);
                    default: while (txt.size() > n + 1) void'(txt.pop_back());
                endcase
            end
        end
        push_text(txt);
    endtask

    // driver: next character offered once the current one has gone
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tlast  <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item  = pending_chars.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= next_item.ch;
                i_s_tlast  <= next_item.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, forced low during the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end

    // hold-off counter, runs once armed
    always @(posedge i_clk) begin
        if (hold_active)
            hold_count <= hold_count + 1;
    end

    // monitor: check results first, then predict from the accepted character
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $realtime,
                             o_m_tdata);
                    mismatch_count++;
                end else begin
                    expected_word = expected_verdicts.pop_front();
                    if (o_m_tdata !== expected_word) begin
                        want = expected_word[26:0];
                        got  = o_m_tdata[26:0];
                        $display({"%0t: result mismatch, expected %h ",
                                  "(ok=%0b br=%0b off=%0b len=%0d port=%0d), actual %h ",
                                  "(ok=%0b br=%0b off=%0b len=%0d port=%0d)"},
                                 $realtime, expected_word, want.ok, want.bracketed,
                                 want.host_offset, want.host_length, want.port_number,
                                 o_m_tdata, got.ok, got.bracketed, got.host_offset,
                                 got.host_length, got.port_number);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                parse_char(i_s_tdata, i_s_tlast);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        t_text txt;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed texts: port limits, empty parts, brackets, stray colons
        push_string("a:1");
        push_string("host.example:65535");
        push_string("h:65536");
        push_string("h:0");
        push_string("h:000");
        push_string("h:0080");
        push_string("h:");
        push_string(":80");
        push_string("[::1]:443");
        push_string("[]:80");
        push_string("[ab]80");
        push_string("[ab]:");
        push_string("a:b:1");
        push_string("a:1x");
        push_string("x");
        push_string("[");
        push_string("h:99999");
        push_string("[a]:1:2");
        push_string("[a:b]:8");
        push_string("a]b:2");
        push_string("[a]x:1");
        txt = '{8'h00, hpp_pkg::CH_COLON, hpp_pkg::CH_NINE};
        push_text(txt);
        txt = '{8'hFF, 8'h80, hpp_pkg::CH_COLON, hpp_pkg::CH_NINE, hpp_pkg::CH_NINE};
        push_text(txt);
        // text exactly at the length limit, one over, and bracketed at the limit
        push_filled_host(1'b0, MAX_TEXT_LENGTH - 3);
        push_filled_host(1'b0, MAX_TEXT_LENGTH - 2);
        push_filled_host(1'b1, MAX_TEXT_LENGTH - 5);

        // random stages: sender idles lightly, then receiver lightly, then neither
        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_armed    = 1'b1;  // receiver holds off while the sender streams
                end
            endcase
            chars_queued = 0;
            while (chars_queued < CHARS_PER_STAGE)
                push_random_text();
            while (pending_chars.size() != 0)
                @(negedge i_clk);
        end

        // drain
        while (pending_chars.size() != 0 || i_s_tvalid)
            @(negedge i_clk);
        while (expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
